// ===== hdl/imc_pkg.sv =====
// shared constants, types and controller command/status structs for the
// inertial offset calibration and magnitude block; no dependencies
package imc_pkg;

    localparam int CAL_SAMPLES = 10;
    localparam int AXES        = 6;
    localparam int SMP_W       = 16;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = 4;
    localparam int DIFF_W      = SMP_W + 1;
    localparam int SQ_W        = 2 * DIFF_W - 1;
    localparam int ACC_W       = SQ_W + 1;
    localparam int MAG_W       = ACC_W / 2;
    localparam int RREM_W      = MAG_W + 1;
    localparam int ROOT_STEPS  = MAG_W;
    localparam int STEP_W      = 5;
    localparam int SQ_LAST     = 3;

    // reciprocal of the run length, rounded up; exact for any sum magnitude below 2^SUM_W
    localparam int DIV_SHIFT   = SUM_W + 4;
    localparam int DIV_MUL_W   = DIV_SHIFT + 1;
    localparam int QPROD_W     = SUM_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'((2 ** DIV_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL,
        S_DIV_LOAD,
        S_DIV,
        S_DIV_END,
        S_SQ,
        S_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       cap;
        logic       cal_add;
        logic       div_load;
        logic       div_step;
        logic       div_end;
        logic       sq_step;
        logic [1:0] sq_idx;
        logic       root_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic cal_last;
    } t_sts;

endpackage

// ===== hdl/imc_in_if.sv =====
// input sample channel: valid/ready handshake with op and six raw axes
// depends on imc_pkg
interface imc_in_if import imc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_z;

    modport source (
        output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        input  ready
    );
    modport sink (
        input  valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        output ready
    );
endinterface

// ===== hdl/imc_out_if.sv =====
// result channel: valid/ready handshake with magnitudes and calibration status
// depends on imc_pkg
interface imc_out_if import imc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] accel_magnitude;
    logic [MAG_W-1:0] rotation_magnitude;
    logic             offsets_updated;
    logic [CNT_W-1:0] samples_taken;

    modport source (
        output valid, accel_magnitude, rotation_magnitude, offsets_updated,
        samples_taken,
        input  ready
    );
    modport sink (
        input  valid, accel_magnitude, rotation_magnitude, offsets_updated,
        samples_taken,
        output ready
    );
endinterface

// ===== hdl/imc_datapath.sv =====
// datapath: sample capture, calibration sums and offsets, constant divider,
// squaring and two digit-by-digit square roots; depends on imc_pkg
module imc_datapath import imc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_op,
    input  logic signed [SMP_W-1:0] i_accel_x,
    input  logic signed [SMP_W-1:0] i_accel_y,
    input  logic signed [SMP_W-1:0] i_accel_z,
    input  logic signed [SMP_W-1:0] i_gyro_x,
    input  logic signed [SMP_W-1:0] i_gyro_y,
    input  logic signed [SMP_W-1:0] i_gyro_z,
    output logic [MAG_W-1:0]        o_accel_magnitude,
    output logic [MAG_W-1:0]        o_rotation_magnitude,
    output logic                    o_offsets_updated,
    output logic [CNT_W-1:0]        o_samples_taken
);

    localparam logic [CNT_W:0]   CAL_C = (CNT_W + 1)'(CAL_SAMPLES);

    logic signed [SMP_W-1:0] r_smp [AXES];
    logic                    r_op;
    logic signed [SUM_W-1:0] r_sum [AXES];
    logic signed [SMP_W-1:0] r_off [AXES];
    logic [CNT_W-1:0]        r_count;
    logic                    r_upd;

    // divider lanes, one per axis: sum magnitude times the reciprocal
    logic                    r_neg   [AXES];
    logic [SUM_W-1:0]        r_dq    [AXES];
    logic [SMP_W-1:0]        r_quo   [AXES];
    logic [QPROD_W-1:0]      w_qprod [AXES];

    // squaring: lane 0 accel, lane 1 gyro
    logic signed [DIFF_W-1:0]   w_diff [2];
    logic signed [2*DIFF_W-1:0] w_prod [2];
    logic [SQ_W-1:0]            r_prod [2];
    logic [ACC_W-1:0]           r_acc  [2];
    logic [ACC_W-1:0]           w_acc_n [2];

    // square root lanes
    logic [ACC_W-1:0]  r_n    [2];
    logic [RREM_W-1:0] r_rr   [2];
    logic [MAG_W-1:0]  r_root [2];
    logic [RREM_W+1:0] w_rr_sh [2];
    logic [RREM_W+1:0] w_trial [2];
    logic              w_rge   [2];

    logic [MAG_W-1:0]  r_amag;
    logic [MAG_W-1:0]  r_rmag;
    logic              r_upd_o;
    logic [CNT_W-1:0]  r_cnt_o;

    logic [CNT_W:0]    w_count_inc;

    assign w_count_inc    = {1'b0, r_count} + 1'b1;
    assign o_sts.cal_last = (w_count_inc >= CAL_C);
    assign o_sts.op       = r_op;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_qprod[k] = QPROD_W'(r_dq[k]) * QPROD_W'(DIV_MUL);
        end
    end

    always_comb begin
        case (i_cmd.sq_idx)
            2'd1: begin
                w_diff[0] = DIFF_W'(r_smp[1]) - DIFF_W'(r_off[1]);
                w_diff[1] = DIFF_W'(r_smp[4]) - DIFF_W'(r_off[4]);
            end
            2'd2: begin
                w_diff[0] = DIFF_W'(r_smp[2]) - DIFF_W'(r_off[2]);
                w_diff[1] = DIFF_W'(r_smp[5]) - DIFF_W'(r_off[5]);
            end
            default: begin
                w_diff[0] = DIFF_W'(r_smp[0]) - DIFF_W'(r_off[0]);
                w_diff[1] = DIFF_W'(r_smp[3]) - DIFF_W'(r_off[3]);
            end
        endcase
        for (int l = 0; l < 2; l++) begin
            w_prod[l]  = w_diff[l] * w_diff[l];
            w_acc_n[l] = r_acc[l] + ACC_W'(r_prod[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rr_sh[l] = {r_rr[l], r_n[l][ACC_W-1 -: 2]};
            w_trial[l] = (RREM_W + 2)'({r_root[l], 2'b01});
            w_rge[l]   = (w_rr_sh[l] >= w_trial[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= '0;
                r_off[k] <= '0;
            end
        end else begin
            if (i_cmd.cal_add) begin
                for (int k = 0; k < AXES; k++) begin
                    r_sum[k] <= r_sum[k] + SUM_W'(r_smp[k]);
                end
                r_count <= o_sts.cal_last ? '0 : w_count_inc[CNT_W-1:0];
            end
            if (i_cmd.div_end) begin
                for (int k = 0; k < AXES; k++) begin
                    r_sum[k] <= '0;
                    r_off[k] <= r_neg[k] ? (~r_quo[k] + 1'b1) : r_quo[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op     <= i_op;
            r_smp[0] <= i_accel_x;
            r_smp[1] <= i_accel_y;
            r_smp[2] <= i_accel_z;
            r_smp[3] <= i_gyro_x;
            r_smp[4] <= i_gyro_y;
            r_smp[5] <= i_gyro_z;
            r_upd    <= 1'b0;
        end
        if (i_cmd.cal_add) begin
            r_upd <= o_sts.cal_last;
        end
        for (int k = 0; k < AXES; k++) begin
            if (i_cmd.div_load) begin
                r_neg[k] <= r_sum[k][SUM_W-1];
                r_dq[k]  <= r_sum[k][SUM_W-1] ? SUM_W'(-r_sum[k]) : SUM_W'(r_sum[k]);
            end
            if (i_cmd.div_step) begin
                r_quo[k] <= w_qprod[k][DIV_SHIFT +: SMP_W];
            end
        end
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.sq_step) begin
                r_prod[l] <= w_prod[l][SQ_W-1:0];
                r_acc[l]  <= (i_cmd.sq_idx == 2'd0) ? '0 : w_acc_n[l];
                // last pass only folds in the final square and primes the root
                if (i_cmd.sq_idx == 2'(SQ_LAST)) begin
                    r_n[l]    <= w_acc_n[l];
                    r_rr[l]   <= '0;
                    r_root[l] <= '0;
                end
            end else if (i_cmd.root_step) begin
                r_n[l]    <= {r_n[l][ACC_W-3:0], 2'b00};
                r_rr[l]   <= w_rge[l] ? RREM_W'(w_rr_sh[l] - w_trial[l])
                                      : RREM_W'(w_rr_sh[l]);
                r_root[l] <= {r_root[l][MAG_W-2:0], w_rge[l]};
            end
        end
        if (i_cmd.load_out) begin
            r_amag  <= (r_op == OP_MEAS) ? r_root[0] : '0;
            r_rmag  <= (r_op == OP_MEAS) ? r_root[1] : '0;
            r_upd_o <= (r_op == OP_CAL) ? r_upd : 1'b0;
            r_cnt_o <= r_count;
        end
    end

    assign o_accel_magnitude    = r_amag;
    assign o_rotation_magnitude = r_rmag;
    assign o_offsets_updated    = r_upd_o;
    assign o_samples_taken      = r_cnt_o;

endmodule

// ===== hdl/imc_ctrl.sv =====
// controller: sequences capture, calibration, division, squaring and root
// steps, and owns both handshakes; depends on imc_pkg
module imc_ctrl import imc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.op == OP_MEAS) ? S_SQ : S_CAL;
                end
            end
            S_CAL:      n_state = i_sts.cal_last ? S_DIV_LOAD : S_DONE;
            S_DIV_LOAD: n_state = S_DIV;
            S_DIV:      n_state = S_DIV_END;
            S_DIV_END:  n_state = S_DONE;
            S_SQ: begin
                if (r_step == STEP_W'(SQ_LAST)) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // op for the state decision comes straight off the port at capture
    always_comb begin
        n_step = r_step;
        case (r_state)
            S_IDLE:     n_step = '0;
            S_SQ: begin
                n_step = (r_step == STEP_W'(SQ_LAST)) ? STEP_W'(ROOT_STEPS - 1)
                                                      : r_step + 1'b1;
            end
            S_ROOT:     n_step = r_step - 1'b1;
            default:    n_step = r_step;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.sq_idx    = r_step[1:0];
        case (r_state)
            S_IDLE:     o_cmd.cap       = i_in_valid;
            S_CAL:      o_cmd.cal_add   = 1'b1;
            S_DIV_LOAD: o_cmd.div_load  = 1'b1;
            S_DIV:      o_cmd.div_step  = 1'b1;
            S_DIV_END:  o_cmd.div_end   = 1'b1;
            S_SQ:       o_cmd.sq_step   = 1'b1;
            S_ROOT:     o_cmd.root_step = 1'b1;
            S_DONE:     o_cmd.load_out  = w_out_free;
            default:    o_cmd.cap       = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/imu_offset_calibration_magnitude_core.sv =====
// top level of the inertial offset calibration and magnitude block
// depends on imc_pkg, imc_in_if, imc_out_if, imc_ctrl and imc_datapath

// One request is taken at a time and gives one result. A calibration request
// adds its sample to the axis sums; when it completes a run, six parallel
// reciprocal multipliers divide the axis sums by the sample count in a single
// registered step. A measurement request makes four passes through two 17x17
// multipliers to square and sum the offset-corrected axes, then 17 steps of
// two digit-by-digit square root units working side by side on acceleration
// and rotation. A new request is taken in the cycle after a result is
// registered, while that result still waits in the output register. Offsets
// and sums start at zero after reset.
module imu_offset_calibration_magnitude_core import imc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imc_in_if.sink      i_smp,
    imc_out_if.source   o_res
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_sts w_sts_ctrl;

    // at capture the controller decides on the op from the port itself
    assign w_sts_ctrl.op       = (i_smp.ready) ? i_smp.op : w_sts.op;
    assign w_sts_ctrl.cal_last = w_sts.cal_last;

    imc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts_ctrl),
        .o_cmd       (w_cmd)
    );

    imc_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_op                 (i_smp.op),
        .i_accel_x            (i_smp.accel_x),
        .i_accel_y            (i_smp.accel_y),
        .i_accel_z            (i_smp.accel_z),
        .i_gyro_x             (i_smp.gyro_x),
        .i_gyro_y             (i_smp.gyro_y),
        .i_gyro_z             (i_smp.gyro_z),
        .o_accel_magnitude    (o_res.accel_magnitude),
        .o_rotation_magnitude (o_res.rotation_magnitude),
        .o_offsets_updated    (o_res.offsets_updated),
        .o_samples_taken      (o_res.samples_taken)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for the inertial offset calibration and magnitude core:
// drives calibration and measurement requests with bursty valid and stalling ready
// and checks each result against an in-bench predictor; depends on imc_pkg and both channel interfaces
module testbench;
    import imc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1075;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 40;

    typedef struct packed {
        logic                       op;
        logic [AXES-1:0][SMP_W-1:0] axis;   // ax ay az gx gy gz
    } imu_sample_t;

    typedef struct packed {
        logic [MAG_W-1:0] accel_mag;
        logic [MAG_W-1:0] rot_mag;
        logic             updated;
        logic [CNT_W-1:0] taken;
    } mag_result_t;

    logic i_clk;
    logic i_rst_n;

    imc_in_if  smp ();
    imc_out_if res ();

    imu_offset_calibration_magnitude_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res)
    );

    imu_sample_t pending_samples [$];
    mag_result_t due_results [$];

    // predictor state
    int axis_sum [AXES];
    int axis_off [AXES];
    int cal_count;

    int   n_errors;
    int   n_requests;
    int   cycles;
    logic in_taken;
    int   gap_left;
    int   burst_left;
    int   hold_left;
    int   holds_done;
    int   stall_mode;
    int   mode_left;
    logic [7:0] ready_pattern;

    always #6 i_clk = ~i_clk;

    function automatic logic [MAG_W-1:0] floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = n;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] vec_magnitude(imu_sample_t s, int first);
        longint diff;
        longint unsigned acc;
        acc = 0;
        for (int k = first; k < first + 3; k++) begin
            diff = longint'($signed(s.axis[k])) - longint'(axis_off[k]);
            acc += longint'(diff * diff);
        end
        return floor_sqrt(acc);
    endfunction

    function automatic mag_result_t apply_sample(imu_sample_t s);
        mag_result_t r;
        r = '0;
        if (s.op == OP_CAL) begin
            for (int k = 0; k < AXES; k++) axis_sum[k] += int'($signed(s.axis[k]));
            cal_count++;
            if (cal_count >= CAL_SAMPLES) begin
                // integer division truncates toward zero
                for (int k = 0; k < AXES; k++) begin
                    axis_off[k] = axis_sum[k] / CAL_SAMPLES;
                    axis_sum[k] = 0;
                end
                cal_count = 0;
                r.updated = 1'b1;
            end
        end else begin
            r.accel_mag = vec_magnitude(s, 0);
            r.rot_mag   = vec_magnitude(s, 3);
        end
        r.taken = cal_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic void queue_sample(logic op, logic [SMP_W-1:0] ax, logic [SMP_W-1:0] ay,
                                         logic [SMP_W-1:0] az, logic [SMP_W-1:0] gx,
                                         logic [SMP_W-1:0] gy, logic [SMP_W-1:0] gz);
        imu_sample_t s;
        s.op      = op;
        s.axis[0] = ax;
        s.axis[1] = ay;
        s.axis[2] = az;
        s.axis[3] = gx;
        s.axis[4] = gy;
        s.axis[5] = gz;
        pending_samples.push_back(s);
    endfunction

    function automatic logic [SMP_W-1:0] raw_count();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin : req_drive
        imu_sample_t s;
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else if (!smp.valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                smp.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s = pending_samples.pop_front();
                smp.op      <= s.op;
                smp.accel_x <= s.axis[0];
                smp.accel_y <= s.axis[1];
                smp.accel_z <= s.axis[2];
                smp.gyro_x  <= s.axis[3];
                smp.gyro_y  <= s.axis[4];
                smp.gyro_z  <= s.axis[5];
                smp.valid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap_left = 0;
                        6, 7:             gap_left = $urandom_range(1, 4);
                        8:                gap_left = $urandom_range(5, 30);
                        default:          gap_left = $urandom_range(20, 60);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // accepted requests feed the predictor
    always @(posedge i_clk) begin : req_capture
        imu_sample_t s;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= smp.valid && smp.ready;
            if (smp.valid && smp.ready) begin
                s.op      = smp.op;
                s.axis[0] = smp.accel_x;
                s.axis[1] = smp.accel_y;
                s.axis[2] = smp.accel_z;
                s.axis[3] = smp.gyro_x;
                s.axis[4] = smp.gyro_y;
                s.axis[5] = smp.gyro_z;
                due_results.push_back(apply_sample(s));
                n_requests <= n_requests + 1;
            end
        end
    end

    // long receiver hold-offs so the core fills up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && n_requests >= 300 + 500 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // receiver ready with changing stall behaviour
    always @(negedge i_clk) begin : res_drive
        logic rdy;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
        if (!i_rst_n || hold_left != 0) begin
            rdy = 1'b0;
        end else begin
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                2:       rdy = ready_pattern[0];
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        res.ready <= rdy;
    end

    // result checker
    always @(posedge i_clk) begin : res_check
        mag_result_t want;
        if (i_rst_n && res.valid && res.ready) begin
            if (due_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                want = due_results.pop_front();
                if (res.accel_magnitude !== want.accel_mag) begin
                    $error("accel_magnitude: expected %0d, got %0d",
                           want.accel_mag, res.accel_magnitude);
                    n_errors++;
                end
                if (res.rotation_magnitude !== want.rot_mag) begin
                    $error("rotation_magnitude: expected %0d, got %0d",
                           want.rot_mag, res.rotation_magnitude);
                    n_errors++;
                end
                if (res.offsets_updated !== want.updated) begin
                    $error("offsets_updated: expected %0d, got %0d",
                           want.updated, res.offsets_updated);
                    n_errors++;
                end
                if (res.samples_taken !== want.taken) begin
                    $error("samples_taken: expected %0d, got %0d",
                           want.taken, res.samples_taken);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin : main
        logic op;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        smp.valid     = 1'b0;
        smp.op        = OP_CAL;
        smp.accel_x   = '0;
        smp.accel_y   = '0;
        smp.accel_z   = '0;
        smp.gyro_x    = '0;
        smp.gyro_y    = '0;
        smp.gyro_z    = '0;
        res.ready     = 1'b0;
        in_taken      = 1'b0;
        n_errors      = 0;
        n_requests    = 0;
        cycles        = 0;
        gap_left      = 0;
        burst_left    = 1;
        hold_left     = 0;
        holds_done    = 0;
        stall_mode    = 0;
        mode_left     = 0;
        ready_pattern = 8'b1011_0010;
        cal_count     = 0;
        for (int k = 0; k < AXES; k++) begin
            axis_sum[k] = 0;
            axis_off[k] = 0;
        end

        // measurements against zero offsets at both extremes
        queue_sample(OP_MEAS, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        queue_sample(OP_MEAS, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        // run at the negative limit, interrupted by a measurement
        repeat (3)
            queue_sample(OP_CAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_sample(OP_MEAS, 16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h0000);
        repeat (7)
            queue_sample(OP_CAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        // widest positive difference
        queue_sample(OP_MEAS, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        // run at the positive limit, then widest negative difference
        repeat (10)
            queue_sample(OP_CAL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        queue_sample(OP_MEAS, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            op = ($urandom_range(0, 1) == 0) ? OP_CAL : OP_MEAS;
            queue_sample(op, raw_count(), raw_count(), raw_count(),
                         raw_count(), raw_count(), raw_count());
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_samples.size() != 0 || smp.valid || due_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        if (n_errors == 0 && due_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
